@@ hdl/tmlo_pkg.sv @@
// Shared constants and types for the tiled matrix layout offset unit.
// No dependencies; the top level, the offset datapath and the testbench import this package.
`timescale 1ns / 1ps

package tmlo_pkg;

    // Default size limits, used as top-level parameter defaults.
    localparam int DEF_MAX_DIM  = 32768;
    localparam int DEF_MAX_TILE = 4096;

    // Fixed port widths.
    localparam int IDX_W  = 15;
    localparam int CNT_W  = 16;
    localparam int TSZ_W  = 13;
    localparam int MODE_W = 3;
    localparam int OFF_W  = 30;
    localparam int REG_W  = 3;
    localparam int DATA_W = 16;

    // Configuration register indexes.
    localparam logic [REG_W-1:0] REG_LAYOUT    = 3'd0;
    localparam logic [REG_W-1:0] REG_ROW_COUNT = 3'd1;
    localparam logic [REG_W-1:0] REG_COL_COUNT = 3'd2;
    localparam logic [REG_W-1:0] REG_TILE_ROWS = 3'd3;
    localparam logic [REG_W-1:0] REG_TILE_COLS = 3'd4;

    // Layout codes.
    localparam logic [MODE_W-1:0] LAYOUT_CM = 3'd0;
    localparam logic [MODE_W-1:0] LAYOUT_RM = 3'd1;
    localparam logic [MODE_W-1:0] LAYOUT_CC = 3'd2;
    localparam logic [MODE_W-1:0] LAYOUT_CR = 3'd3;
    localparam logic [MODE_W-1:0] LAYOUT_RC = 3'd4;
    localparam logic [MODE_W-1:0] LAYOUT_RR = 3'd5;

    // Decoded layout controls handed to the offset datapath.
    typedef struct packed {
        logic tiled;
        logic row_major;
        logic tiles_by_row;
        logic inner_by_row;
    } tmlo_mode_t;

endpackage

@@ hdl/tiled_matrix_layout_offset_unit.sv @@
// Top level of the tiled matrix layout offset unit: configuration registers,
// index dividers and offset datapath. Depends on tmlo_pkg, tmlo_divider, tmlo_offset_calc.
`timescale 1ns / 1ps

//  channel   signals                                     direction
//  command   start, busy, row_index, col_index           in (busy out)
//  result    done, element_offset, out_of_range          out
//  config    wr_en, wr_index, wr_data                    in
//
//  One word is accepted every cycle; busy is always low.
//  Each word passes one divider stage per quotient bit of the index divide
//  (DIM_W = clog2(MAX_DIM+1) quotient bits), then four offset stages.
//  done is high for one cycle per word; the receiver cannot stall.
//  Reset clears the valid pipeline and sets the registers to their defaults.

module tiled_matrix_layout_offset_unit
    import tmlo_pkg::*;
#(
    parameter int MAX_DIM  = DEF_MAX_DIM,
    parameter int MAX_TILE = DEF_MAX_TILE
) (
    input  logic              clk,
    input  logic              rst_n,
    input  logic              start,
    output logic              busy,
    input  logic [IDX_W-1:0]  row_index,
    input  logic [IDX_W-1:0]  col_index,
    output logic              done,
    output logic [OFF_W-1:0]  element_offset,
    output logic              out_of_range,
    input  logic              wr_en,
    input  logic [REG_W-1:0]  wr_index,
    input  logic [DATA_W-1:0] wr_data
);

    localparam int DIM_W = $clog2(MAX_DIM + 1);
    localparam int TW    = $clog2(MAX_TILE + 1);
    localparam int LAT   = DIM_W + 4;

    logic [MODE_W-1:0] layout_reg;
    logic [CNT_W-1:0]  row_count_reg, col_count_reg;
    logic [TSZ_W-1:0]  tile_rows_reg, tile_cols_reg;

    // Configuration writes.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            layout_reg    <= LAYOUT_CM;
            row_count_reg <= CNT_W'(1);
            col_count_reg <= CNT_W'(1);
            tile_rows_reg <= TSZ_W'(1);
            tile_cols_reg <= TSZ_W'(1);
        end
        else if (wr_en)
        begin
            case (wr_index)
                REG_LAYOUT:    layout_reg    <= wr_data[MODE_W-1:0];
                REG_ROW_COUNT: row_count_reg <= wr_data[CNT_W-1:0];
                REG_COL_COUNT: col_count_reg <= wr_data[CNT_W-1:0];
                REG_TILE_ROWS: tile_rows_reg <= wr_data[TSZ_W-1:0];
                REG_TILE_COLS: tile_cols_reg <= wr_data[TSZ_W-1:0];
                default: ;
            endcase
        end
    end

    // Saturated sizes; a zero tile size acts as one.
    logic [DIM_W-1:0] m, n;
    logic [TW-1:0]    mb, nb;
    assign m  = (32'(row_count_reg) > MAX_DIM) ? DIM_W'(MAX_DIM) : DIM_W'(row_count_reg);
    assign n  = (32'(col_count_reg) > MAX_DIM) ? DIM_W'(MAX_DIM) : DIM_W'(col_count_reg);
    assign mb = (tile_rows_reg == '0) ? TW'(1) :
                (32'(tile_rows_reg) > MAX_TILE) ? TW'(MAX_TILE) : TW'(tile_rows_reg);
    assign nb = (tile_cols_reg == '0) ? TW'(1) :
                (32'(tile_cols_reg) > MAX_TILE) ? TW'(MAX_TILE) : TW'(tile_cols_reg);

    // Layout decode; unused codes fall back to column-major.
    tmlo_mode_t mode;
    always_comb
    begin
        mode = '0;
        case (layout_reg)
            LAYOUT_RM: mode.row_major = 1'b1;
            LAYOUT_CC: mode.tiled = 1'b1;
            LAYOUT_CR: mode = '{tiled: 1'b1, row_major: 1'b0,
                                tiles_by_row: 1'b0, inner_by_row: 1'b1};
            LAYOUT_RC: mode = '{tiled: 1'b1, row_major: 1'b0,
                                tiles_by_row: 1'b1, inner_by_row: 1'b0};
            LAYOUT_RR: mode = '{tiled: 1'b1, row_major: 1'b0,
                                tiles_by_row: 1'b1, inner_by_row: 1'b1};
            default:   mode = '0;
        endcase
    end

    logic accept, oor_in;
    assign busy   = 1'b0;
    assign accept = start && !busy;
    assign oor_in = (32'(row_index) >= 32'(m)) || (32'(col_index) >= 32'(n));

    // Row and column index dividers.
    logic             dv_valid, dv_valid_c, oor_d;
    logic [DIM_W-1:0] ti, tj, mq, nq, i_d, j_d;
    logic [TW-1:0]    ii, jj, mr, nr;

    tmlo_divider #(.DW(DIM_W), .VW(TW), .SW(DIM_W + 1)) u_row_div (
        .clk        (clk),
        .rst_n      (rst_n),
        .in_valid   (accept),
        .dividend_a (DIM_W'(row_index)),
        .dividend_b (m),
        .divisor    (mb),
        .side_in    ({DIM_W'(row_index), oor_in}),
        .out_valid  (dv_valid),
        .quot_a     (ti),
        .rem_a      (ii),
        .quot_b     (mq),
        .rem_b      (mr),
        .side_out   ({i_d, oor_d})
    );

    tmlo_divider #(.DW(DIM_W), .VW(TW), .SW(DIM_W)) u_col_div (
        .clk        (clk),
        .rst_n      (rst_n),
        .in_valid   (accept),
        .dividend_a (DIM_W'(col_index)),
        .dividend_b (n),
        .divisor    (nb),
        .side_in    (DIM_W'(col_index)),
        .out_valid  (dv_valid_c),
        .quot_a     (tj),
        .rem_a      (jj),
        .quot_b     (nq),
        .rem_b      (nr),
        .side_out   (j_d)
    );

    // Offset datapath.
    tmlo_offset_calc #(.DW(DIM_W), .TW(TW)) u_calc (
        .clk      (clk),
        .rst_n    (rst_n),
        .in_valid (dv_valid),
        .mode     (mode),
        .m        (m),
        .n        (n),
        .mb       (mb),
        .nb       (nb),
        .ti       (ti),
        .ii       (ii),
        .tj       (tj),
        .jj       (jj),
        .mq       (mq),
        .mr       (mr),
        .nq       (nq),
        .nr       (nr),
        .i        (i_d),
        .j        (j_d),
        .oor_in   (oor_d),
        .done     (done),
        .offset   (element_offset),
        .oor_out  (out_of_range)
    );

    // Both dividers advance in lockstep.
    assert property (@(posedge clk) disable iff (!rst_n) dv_valid == dv_valid_c)
        else $error("row and column dividers out of step");

    // Every accepted word comes out after the fixed latency.
    assert property (@(posedge clk) disable iff (!rst_n) accept |-> ##LAT done)
        else $error("accepted word did not produce a result");

    // An out-of-range word reports a zero offset.
    assert property (@(posedge clk) disable iff (!rst_n)
                     (done && out_of_range) |-> (element_offset == '0))
        else $error("out-of-range result with nonzero offset");

endmodule

@@ hdl/tmlo_divider.sv @@
// Pipelined restoring divider: two dividends over one shared divisor,
// one quotient bit per stage, with a side payload carried alongside.
// Depends on nothing outside this file.
`timescale 1ns / 1ps

module tmlo_divider #(
    parameter int DW = 16,
    parameter int VW = 13,
    parameter int SW = 1
) (
    input  logic          clk,
    input  logic          rst_n,
    input  logic          in_valid,
    input  logic [DW-1:0] dividend_a,
    input  logic [DW-1:0] dividend_b,
    input  logic [VW-1:0] divisor,
    input  logic [SW-1:0] side_in,
    output logic          out_valid,
    output logic [DW-1:0] quot_a,
    output logic [VW-1:0] rem_a,
    output logic [DW-1:0] quot_b,
    output logic [VW-1:0] rem_b,
    output logic [SW-1:0] side_out
);

    // Stage registers; entry s holds the word after s+1 quotient bits.
    logic          valid_reg [DW];
    logic [VW-1:0] div_reg   [DW];
    logic [SW-1:0] side_reg  [DW];
    logic [DW-1:0] a_rest_reg [DW];
    logic [DW-1:0] a_quo_reg  [DW];
    logic [VW-1:0] a_rem_reg  [DW];
    logic [DW-1:0] b_rest_reg [DW];
    logic [DW-1:0] b_quo_reg  [DW];
    logic [VW-1:0] b_rem_reg  [DW];

    // One restoring step: result is {quotient bit, new remainder}.
    function automatic logic [VW:0] div_step(input logic [VW-1:0] rem,
                                             input logic bit_in,
                                             input logic [VW-1:0] d);
        logic [VW:0] trial;
        logic [VW:0] diff;
        trial = {rem, bit_in};
        diff  = trial - {1'b0, d};
        if (trial >= {1'b0, d})
            return {1'b1, diff[VW-1:0]};
        else
            return {1'b0, trial[VW-1:0]};
    endfunction

    // Valid bits travel with the data.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            for (int s = 0; s < DW; s++)
                valid_reg[s] <= 1'b0;
        end
        else
        begin
            valid_reg[0] <= in_valid;
            for (int s = 1; s < DW; s++)
                valid_reg[s] <= valid_reg[s-1];
        end
    end

    // Datapath stages.
    always_ff @(posedge clk)
    begin
        logic [VW:0] sa;
        logic [VW:0] sb;
        sa = div_step('0, dividend_a[DW-1], divisor);
        sb = div_step('0, dividend_b[DW-1], divisor);
        div_reg[0]    <= divisor;
        side_reg[0]   <= side_in;
        a_rest_reg[0] <= dividend_a << 1;
        a_quo_reg[0]  <= {{(DW-1){1'b0}}, sa[VW]};
        a_rem_reg[0]  <= sa[VW-1:0];
        b_rest_reg[0] <= dividend_b << 1;
        b_quo_reg[0]  <= {{(DW-1){1'b0}}, sb[VW]};
        b_rem_reg[0]  <= sb[VW-1:0];
        for (int s = 1; s < DW; s++)
        begin
            sa = div_step(a_rem_reg[s-1], a_rest_reg[s-1][DW-1], div_reg[s-1]);
            sb = div_step(b_rem_reg[s-1], b_rest_reg[s-1][DW-1], div_reg[s-1]);
            div_reg[s]    <= div_reg[s-1];
            side_reg[s]   <= side_reg[s-1];
            a_rest_reg[s] <= a_rest_reg[s-1] << 1;
            a_quo_reg[s]  <= {a_quo_reg[s-1][DW-2:0], sa[VW]};
            a_rem_reg[s]  <= sa[VW-1:0];
            b_rest_reg[s] <= b_rest_reg[s-1] << 1;
            b_quo_reg[s]  <= {b_quo_reg[s-1][DW-2:0], sb[VW]};
            b_rem_reg[s]  <= sb[VW-1:0];
        end
    end

    assign out_valid = valid_reg[DW-1];
    assign quot_a    = a_quo_reg[DW-1];
    assign rem_a     = a_rem_reg[DW-1];
    assign quot_b    = b_quo_reg[DW-1];
    assign rem_b     = b_rem_reg[DW-1];
    assign side_out  = side_reg[DW-1];

endmodule

@@ hdl/tmlo_offset_calc.sv @@
// Four-stage offset datapath: region products, partial sums, full-tile base,
// final selection. Depends on tmlo_pkg.
`timescale 1ns / 1ps

module tmlo_offset_calc
    import tmlo_pkg::*;
#(
    parameter int DW = 16,
    parameter int TW = 13
) (
    input  logic             clk,
    input  logic             rst_n,
    input  logic             in_valid,
    input  tmlo_mode_t       mode,
    input  logic [DW-1:0]    m,
    input  logic [DW-1:0]    n,
    input  logic [TW-1:0]    mb,
    input  logic [TW-1:0]    nb,
    input  logic [DW-1:0]    ti,
    input  logic [TW-1:0]    ii,
    input  logic [DW-1:0]    tj,
    input  logic [TW-1:0]    jj,
    input  logic [DW-1:0]    mq,
    input  logic [TW-1:0]    mr,
    input  logic [DW-1:0]    nq,
    input  logic [TW-1:0]    nr,
    input  logic [DW-1:0]    i,
    input  logic [DW-1:0]    j,
    input  logic             oor_in,
    output logic             done,
    output logic [OFF_W-1:0] offset,
    output logic             oor_out
);

    typedef logic [OFF_W-1:0] off_t;

    // Stage one registers.
    logic       v1_reg, oor1_reg, in_i1_reg, in_j1_reg;
    off_t       inner_mul_reg, inner_add_reg, idx_mul_reg, idx_add_reg;
    off_t       area1_reg, mn0_reg, m0n_reg, m0n0_reg, nrm0_reg;
    off_t       nbmr_reg, mbnr_reg, ti1_reg, tj1_reg, lin_mul_reg, lin_add_reg;
    // Stage two registers.
    logic       v2_reg, oor2_reg, in_i2_reg, in_j2_reg;
    off_t       inner2_reg, idx2_reg, area2_reg, bottom2_reg, right2_reg;
    off_t       corner2_reg, lin2_reg;
    // Stage three registers.
    logic       v3_reg, oor3_reg, in_i3_reg, in_j3_reg;
    off_t       inner3_reg, full3_reg, bottom3_reg, right3_reg, corner3_reg, lin3_reg;
    // Output registers.
    logic       done_reg, oor_out_reg;
    off_t       offset_reg;

    // Edge region bounds and the height and width of the tile that holds the element.
    logic [DW-1:0] m0, n0;
    logic          in_i, in_j;
    logic [TW-1:0] h, w;
    assign m0   = m - DW'(mr);
    assign n0   = n - DW'(nr);
    assign in_i = ti < mq;
    assign in_j = tj < nq;
    assign h    = in_i ? mb : mr;
    assign w    = in_j ? nb : nr;

    // Valid and flag pipeline.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            v1_reg   <= 1'b0;
            v2_reg   <= 1'b0;
            v3_reg   <= 1'b0;
            done_reg <= 1'b0;
        end
        else
        begin
            v1_reg   <= in_valid;
            v2_reg   <= v1_reg;
            v3_reg   <= v2_reg;
            done_reg <= v3_reg;
        end
    end

    // Stage one: at most one product per register.
    always_ff @(posedge clk)
    begin
        oor1_reg      <= oor_in;
        in_i1_reg     <= in_i;
        in_j1_reg     <= in_j;
        inner_mul_reg <= mode.inner_by_row ? off_t'(ii) * off_t'(w)
                                           : off_t'(jj) * off_t'(h);
        inner_add_reg <= mode.inner_by_row ? off_t'(jj) : off_t'(ii);
        idx_mul_reg   <= mode.tiles_by_row ? off_t'(ti) * off_t'(nq)
                                           : off_t'(tj) * off_t'(mq);
        idx_add_reg   <= mode.tiles_by_row ? off_t'(tj) : off_t'(ti);
        area1_reg     <= off_t'(mb) * off_t'(nb);
        mn0_reg       <= off_t'(m) * off_t'(n0);
        m0n_reg       <= off_t'(m0) * off_t'(n);
        m0n0_reg      <= off_t'(m0) * off_t'(n0);
        nrm0_reg      <= off_t'(nr) * off_t'(m0);
        nbmr_reg      <= off_t'(nb) * off_t'(mr);
        mbnr_reg      <= off_t'(mb) * off_t'(nr);
        ti1_reg       <= off_t'(ti);
        tj1_reg       <= off_t'(tj);
        lin_mul_reg   <= mode.row_major ? off_t'(i) * off_t'(n) : off_t'(j) * off_t'(m);
        lin_add_reg   <= mode.row_major ? off_t'(j) : off_t'(i);
    end

    // Stage two: strip bases and partial sums.
    always_ff @(posedge clk)
    begin
        oor2_reg    <= oor1_reg;
        in_i2_reg   <= in_i1_reg;
        in_j2_reg   <= in_j1_reg;
        inner2_reg  <= inner_mul_reg + inner_add_reg;
        idx2_reg    <= idx_mul_reg + idx_add_reg;
        area2_reg   <= area1_reg;
        bottom2_reg <= (mode.tiles_by_row ? m0n_reg : m0n0_reg) + tj1_reg * nbmr_reg;
        right2_reg  <= (mode.tiles_by_row ? m0n0_reg : mn0_reg) + ti1_reg * mbnr_reg;
        corner2_reg <= mn0_reg + nrm0_reg;
        lin2_reg    <= lin_mul_reg + lin_add_reg;
    end

    // Stage three: base of a full tile.
    always_ff @(posedge clk)
    begin
        oor3_reg    <= oor2_reg;
        in_i3_reg   <= in_i2_reg;
        in_j3_reg   <= in_j2_reg;
        inner3_reg  <= inner2_reg;
        full3_reg   <= idx2_reg * area2_reg;
        bottom3_reg <= bottom2_reg;
        right3_reg  <= right2_reg;
        corner3_reg <= corner2_reg;
        lin3_reg    <= lin2_reg;
    end

    // Stage four: region and layout selection; out-of-range words give zero.
    always_ff @(posedge clk)
    begin
        off_t base;
        if (in_i3_reg && in_j3_reg)
            base = full3_reg;
        else if (in_j3_reg)
            base = bottom3_reg;
        else if (in_i3_reg)
            base = right3_reg;
        else
            base = corner3_reg;
        oor_out_reg <= oor3_reg;
        if (oor3_reg)
            offset_reg <= '0;
        else if (mode.tiled)
            offset_reg <= base + inner3_reg;
        else
            offset_reg <= lin3_reg;
    end

    assign done    = done_reg;
    assign offset  = offset_reg;
    assign oor_out = oor_out_reg;

endmodule

@@ test/tb.sv @@
// Self-checking testbench for the tiled matrix layout offset unit.
// Depends on tmlo_pkg and tiled_matrix_layout_offset_unit; prediction is done locally.
`timescale 1ns / 1ps

module tb;
    import tmlo_pkg::*;

    // Unused layout codes, expected to fall back to column-major.
    localparam logic [MODE_W-1:0] LAYOUT_SPARE_LO = 3'd6;
    localparam logic [MODE_W-1:0] LAYOUT_SPARE_HI = 3'd7;
    localparam int LIM_DIM  = 32768;
    localparam int LIM_TILE = 4096;
    localparam int DRAIN_CYCLES = 30;

    typedef struct packed {
        logic [OFF_W-1:0] offset;
        logic             oor;
    } offset_word_t;

    logic              clk;
    logic              rst_n;
    logic              start;
    logic              busy;
    logic [IDX_W-1:0]  row_index;
    logic [IDX_W-1:0]  col_index;
    logic              done;
    logic [OFF_W-1:0]  element_offset;
    logic              out_of_range;
    logic              wr_en;
    logic [REG_W-1:0]  wr_index;
    logic [DATA_W-1:0] wr_data;

    // Shadow copy of the configuration registers.
    logic [MODE_W-1:0] cur_mode;
    logic [CNT_W-1:0]  cur_rows;
    logic [CNT_W-1:0]  cur_cols;
    logic [TSZ_W-1:0]  cur_tile_rows;
    logic [TSZ_W-1:0]  cur_tile_cols;

    offset_word_t pending_offsets[$];
    int words_sent;
    int words_checked;
    int mismatches;
    int oor_seen;

    tiled_matrix_layout_offset_unit uut (
        .clk(clk), .rst_n(rst_n), .start(start), .busy(busy),
        .row_index(row_index), .col_index(col_index),
        .done(done), .element_offset(element_offset), .out_of_range(out_of_range),
        .wr_en(wr_en), .wr_index(wr_index), .wr_data(wr_data)
    );

    initial
    begin
        clk = 1'b0;
        forever #1 clk = ~clk;
    end

    // Offset of element (i, j) for the current configuration.
    function automatic offset_word_t predict_offset(input logic [IDX_W-1:0] ri,
                                                    input logic [IDX_W-1:0] ci);
        longint unsigned i, j, m, n, mb, nb, mr, nr, m0, n0;
        longint unsigned ti, tj, ii, jj, h, w, inner, base, off;
        logic by_row, in_row;
        offset_word_t res;
        i = ri;
        j = ci;
        m = (cur_rows > LIM_DIM) ? LIM_DIM : cur_rows;
        n = (cur_cols > LIM_DIM) ? LIM_DIM : cur_cols;
        mb = (cur_tile_rows == 0) ? 1 : ((cur_tile_rows > LIM_TILE) ? LIM_TILE : cur_tile_rows);
        nb = (cur_tile_cols == 0) ? 1 : ((cur_tile_cols > LIM_TILE) ? LIM_TILE : cur_tile_cols);
        if (i >= m || j >= n)
        begin
            res.offset = '0;
            res.oor = 1'b1;
            return res;
        end
        if (cur_mode == LAYOUT_RM)
            off = i * n + j;
        else if (cur_mode == LAYOUT_CC || cur_mode == LAYOUT_CR ||
                 cur_mode == LAYOUT_RC || cur_mode == LAYOUT_RR)
        begin
            by_row = (cur_mode == LAYOUT_RC || cur_mode == LAYOUT_RR);
            in_row = (cur_mode == LAYOUT_CR || cur_mode == LAYOUT_RR);
            mr = m % mb;
            nr = n % nb;
            m0 = m - mr;
            n0 = n - nr;
            ti = i / mb;
            tj = j / nb;
            ii = i % mb;
            jj = j % nb;
            h = (i < m0) ? mb : mr;
            w = (j < n0) ? nb : nr;
            inner = in_row ? ii * w + jj : ii + jj * h;
            // Full tiles first, then the edge strips, then the corner.
            if (j < n0 && i < m0)
                base = (by_row ? ti * (n / nb) + tj : ti + tj * (m / mb)) * mb * nb;
            else if (j < n0)
                base = (by_row ? m0 * n : m0 * n0) + tj * nb * mr;
            else if (i < m0)
                base = (by_row ? m0 * n0 : m * n0) + ti * mb * nr;
            else
                base = m * n0 + (n - n0) * m0;
            off = base + inner;
        end
        else
            off = i + j * m;
        res.offset = off[OFF_W-1:0];
        res.oor = 1'b0;
        return res;
    endfunction

    // Compare each returned word with the oldest prediction.
    always @(posedge clk)
    begin
        offset_word_t exp_w;
        if (rst_n && done)
        begin
            if (pending_offsets.size() == 0)
            begin
                mismatches++;
                if (mismatches <= 10)
                    $display("ERROR: unexpected result word offset=%0d oor=%0b",
                             element_offset, out_of_range);
            end
            else
            begin
                exp_w = pending_offsets.pop_front();
                words_checked++;
                if (exp_w.oor)
                    oor_seen++;
                if (element_offset !== exp_w.offset || out_of_range !== exp_w.oor)
                begin
                    mismatches++;
                    if (mismatches <= 10)
                        $display("ERROR: word %0d expected offset=%0d oor=%0b, got offset=%0d oor=%0b",
                                 words_checked, exp_w.offset, exp_w.oor,
                                 element_offset, out_of_range);
                end
            end
        end
    end

    // Send one index pair after a random gap; start stays high across back-to-back words.
    task automatic send_index(input logic [IDX_W-1:0] ri, input logic [IDX_W-1:0] ci);
        int gap;
        gap = $urandom_range(0, 7);
        if ($urandom_range(0, 3) == 0)
            gap = 0;
        if (gap > 0)
        begin
            start <= 1'b0;
            repeat (gap) @(posedge clk);
        end
        start <= 1'b1;
        row_index <= ri;
        col_index <= ci;
        @(posedge clk);
        while (busy)
            @(posedge clk);
        pending_offsets.push_back(predict_offset(ri, ci));
        words_sent++;
    endtask

    // Wait until every word in flight has returned, then let the pipeline drain.
    task automatic wait_idle();
        start <= 1'b0;
        @(posedge clk);
        while (pending_offsets.size() != 0)
            @(posedge clk);
        repeat (DRAIN_CYCLES) @(posedge clk);
    endtask

    // Write all five registers while the unit is idle.
    task automatic load_config(input logic [MODE_W-1:0] mode, input logic [CNT_W-1:0] rows,
                               input logic [CNT_W-1:0] cols, input logic [TSZ_W-1:0] tr,
                               input logic [TSZ_W-1:0] tc);
        wait_idle();
        wr_en <= 1'b1;
        wr_index <= REG_LAYOUT;    wr_data <= DATA_W'(mode); @(posedge clk);
        wr_index <= REG_ROW_COUNT; wr_data <= rows;          @(posedge clk);
        wr_index <= REG_COL_COUNT; wr_data <= cols;          @(posedge clk);
        wr_index <= REG_TILE_ROWS; wr_data <= DATA_W'(tr);   @(posedge clk);
        wr_index <= REG_TILE_COLS; wr_data <= DATA_W'(tc);   @(posedge clk);
        wr_en <= 1'b0;
        cur_mode = mode;
        cur_rows = rows;
        cur_cols = cols;
        cur_tile_rows = tr;
        cur_tile_cols = tc;
    endtask

    // Index within the matrix most of the time, any 15-bit value otherwise.
    function automatic logic [IDX_W-1:0] pick_index(input logic [CNT_W-1:0] cnt);
        int lim;
        lim = (cnt > LIM_DIM) ? LIM_DIM : cnt;
        if (lim == 0 || $urandom_range(0, 9) < 2)
            return IDX_W'($urandom);
        return IDX_W'($urandom_range(0, lim - 1));
    endfunction

    // Reset defaults: a 1 by 1 column-major matrix.
    task automatic test_reset_defaults();
        send_index(0, 0);
        send_index(1, 0);
        send_index(0, 1);
        send_index('1, '1);
    endtask

    // Every layout code on a matrix with partial edge tiles, hitting each region.
    task automatic test_layouts();
        logic [MODE_W-1:0] modes[8];
        modes = '{LAYOUT_CM, LAYOUT_RM, LAYOUT_CC, LAYOUT_CR,
                  LAYOUT_RC, LAYOUT_RR, LAYOUT_SPARE_LO, LAYOUT_SPARE_HI};
        foreach (modes[k])
        begin
            load_config(modes[k], 7, 10, 3, 4);
            send_index(1, 2);
            send_index(6, 1);
            send_index(2, 9);
            send_index(6, 9);
        end
    endtask

    // Extreme sizes, saturation, zero sizes and tiles larger than the matrix.
    task automatic test_size_extremes();
        load_config(LAYOUT_RR, 16'd32768, 16'd32768, 13'd4096, 13'd4096);
        send_index('1, '1);
        send_index('1, 0);
        send_index(0, '1);
        load_config(LAYOUT_CC, 16'hFFFF, 16'hFFFF, 13'h1FFF, 13'h1FFF);
        send_index('1, '1);
        send_index(15'h5555, 15'h2AAA);
        load_config(LAYOUT_RC, 16'd0, 16'd5, 13'd0, 13'd0);
        send_index(0, 0);
        load_config(LAYOUT_CR, 16'd5, 16'd0, 13'd2, 13'd2);
        send_index(0, 0);
        load_config(LAYOUT_CR, 16'd5, 16'd6, 13'd9, 13'd8);
        send_index(4, 5);
        send_index(2, 3);
        send_index(5, 0);
    endtask

    // Random configurations, mostly small, with random words in each.
    task automatic test_random_words();
        logic [CNT_W-1:0] rows, cols;
        logic [TSZ_W-1:0] tr, tc;
        for (int phase = 0; phase < 24; phase++)
        begin
            if (phase % 6 == 5)
            begin
                rows = CNT_W'($urandom);
                cols = CNT_W'($urandom);
                tr = TSZ_W'($urandom);
                tc = TSZ_W'($urandom);
            end
            else
            begin
                rows = CNT_W'($urandom_range(1, 70));
                cols = CNT_W'($urandom_range(1, 70));
                tr = TSZ_W'($urandom_range(0, 20));
                tc = TSZ_W'($urandom_range(0, 20));
            end
            load_config(MODE_W'($urandom), rows, cols, tr, tc);
            for (int k = 0; k < 47; k++)
                send_index(pick_index(rows), pick_index(cols));
        end
    endtask

    initial
    begin
        rst_n = 1'b0;
        start = 1'b0;
        row_index = '0;
        col_index = '0;
        wr_en = 1'b0;
        wr_index = REG_LAYOUT;
        wr_data = '0;
        cur_mode = LAYOUT_CM;
        cur_rows = 1;
        cur_cols = 1;
        cur_tile_rows = 1;
        cur_tile_cols = 1;
        words_sent = 0;
        words_checked = 0;
        mismatches = 0;
        oor_seen = 0;
        repeat (8) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        test_reset_defaults();
        test_layouts();
        test_size_extremes();
        test_random_words();

        wait_idle();
        $display("Checked %0d of %0d words over all eight layout codes; %0d out-of-range.",
                 words_checked, words_sent, oor_seen);
        if (mismatches == 0 && pending_offsets.size() == 0)
            $display("*** PASSED ***");
        else
            $display("*** FAILED ***");
        $finish;
    end

    // Run limit.
    initial
    begin
        #2000000;
        $display("Timeout waiting for result words.");
        $display("*** FAILED ***");
        $finish;
    end

endmodule

@@ filelist.f @@
hdl/tmlo_pkg.sv
hdl/tmlo_divider.sv
hdl/tmlo_offset_calc.sv
hdl/tiled_matrix_layout_offset_unit.sv
test/tb.sv
